/* sv/fdtd_maxwell_2d_cell_update_unit_assert.svh */
// ----------------------------------------------------------------------------
// FDTD cell update unit assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef FDTD_MAXWELL_2D_CELL_UPDATE_UNIT_ASSERT_SVH
`define FDTD_MAXWELL_2D_CELL_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FDTD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FDTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FDTD_ASSERT_IMPL(lbl, ante, cons)
`define FDTD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/fdtd_pkg.sv */
// ----------------------------------------------------------------------------
// FDTD package
// Shared types, constants and arithmetic helpers of the FDTD cell unit.
// ----------------------------------------------------------------------------
package fdtd_pkg;
    localparam int unsigned MaxNx = 256;
    localparam int unsigned MaxNy = 256;
    localparam int unsigned XW = $clog2(MaxNx);
    localparam int unsigned YW = $clog2(MaxNy);
    localparam int unsigned AW = XW + YW;

    localparam logic [2:0] REQ_WRITE_E   = 3'd0;
    localparam logic [2:0] REQ_WRITE_B   = 3'd1;
    localparam logic [2:0] REQ_ADVANCE_B = 3'd2;
    localparam logic [2:0] REQ_ADVANCE_E = 3'd3;

    localparam logic [2:0] CFG_GRID_W  = 3'd0;
    localparam logic [2:0] CFG_GRID_H  = 3'd1;
    localparam logic [2:0] CFG_DT_DX   = 3'd2;
    localparam logic [2:0] CFG_DT_DY   = 3'd3;
    localparam logic [2:0] CFG_C2_DX   = 3'd4;
    localparam logic [2:0] CFG_C2_DY   = 3'd5;
    localparam logic [2:0] CFG_DT_EPS  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_RD_CENTER,
        ST_RD_NX,
        ST_RD_NY,
        ST_CALC,
        ST_SUM,
        ST_WRITE
    } state_t;

    // Six field words of one cell.
    typedef struct packed {
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
    } cell_t;

    // Memory port command from the sequencer.
    typedef struct packed {
        logic          rd;
        logic          we_e;
        logic          we_b;
        logic [AW-1:0] addr;
    } mem_cmd_t;

    // round(val * coef / 2^24), ties away from zero; val has 33 bits.
    function automatic logic signed [41:0] scale_term(logic signed [32:0] val,
                                                      logic [31:0] coef);
        logic        neg;
        logic [32:0] mag;
        logic [64:0] prod;
        logic [40:0] rnd;
        neg  = val[32];
        mag  = neg ? 33'(-val) : 33'(val);
        prod = 65'(mag[31:0]) * 65'(coef);
        rnd  = 41'((prod + 65'(1 << 23)) >> 24);
        return neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    endfunction

    function automatic logic [31:0] sat32(logic signed [43:0] v);
        if (v > 44'sd2147483647) return 32'h7fff_ffff;
        if (v < -44'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction
endpackage

/* sv/fdtd_field_mem.sv */
// ----------------------------------------------------------------------------
// FDTD field memory
// Six field words per cell, E and B halves written separately, one read port.
// ----------------------------------------------------------------------------
module fdtd_field_mem
    import fdtd_pkg::*;
(
    input  logic     clk,
    input  mem_cmd_t cmd,
    input  cell_t    wdata,
    output cell_t    rdata
);
    logic [95:0] e_mem [MaxNx*MaxNy];
    logic [95:0] b_mem [MaxNx*MaxNy];

    always_ff @(posedge clk)
    begin
        if (cmd.we_e)
        begin
            e_mem[cmd.addr] <= {wdata.ex, wdata.ey, wdata.ez};
        end
        if (cmd.we_b)
        begin
            b_mem[cmd.addr] <= {wdata.bx, wdata.by, wdata.bz};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata <= {e_mem[cmd.addr], b_mem[cmd.addr]};
        end
    end
endmodule

/* sv/fdtd_datapath.sv */
// ----------------------------------------------------------------------------
// FDTD datapath
// Differences, scaled terms and saturated sums of one cell update.
// ----------------------------------------------------------------------------
module fdtd_datapath
    import fdtd_pkg::*;
(
    input  logic        clk,
    input  logic        cap_center,
    input  logic        cap_nx,
    input  logic        cap_ny,
    input  logic        calc,
    input  logic        adv_b,
    input  cell_t       rdata,
    input  logic [31:0] jx,
    input  logic [31:0] jy,
    input  logic [31:0] jz,
    input  logic [31:0] k_dx,
    input  logic [31:0] k_dy,
    input  logic [31:0] k_c2dx,
    input  logic [31:0] k_c2dy,
    input  logic [31:0] k_eps,
    output cell_t       result
);
    cell_t c_reg, nx_reg, ny_reg;
    logic signed [41:0] t_reg [7];

    logic signed [32:0] d [4];
    logic signed [41:0] t_next [7];

    always_ff @(posedge clk)
    begin
        if (cap_center) c_reg  <= rdata;
        if (cap_nx)     nx_reg <= rdata;
        if (cap_ny)     ny_reg <= rdata;
    end

    always_comb
    begin
        if (adv_b)
        begin
            d[0] = $signed({ny_reg.ez[31], ny_reg.ez}) - $signed({c_reg.ez[31], c_reg.ez});
            d[1] = $signed({nx_reg.ez[31], nx_reg.ez}) - $signed({c_reg.ez[31], c_reg.ez});
            d[2] = $signed({nx_reg.ey[31], nx_reg.ey}) - $signed({c_reg.ey[31], c_reg.ey});
            d[3] = $signed({ny_reg.ex[31], ny_reg.ex}) - $signed({c_reg.ex[31], c_reg.ex});
            t_next[0] = scale_term(d[0], k_dy);
            t_next[1] = scale_term(d[1], k_dx);
            t_next[2] = scale_term(d[2], k_dx);
            t_next[3] = scale_term(d[3], k_dy);
        end
        else
        begin
            d[0] = $signed({c_reg.bz[31], c_reg.bz}) - $signed({ny_reg.bz[31], ny_reg.bz});
            d[1] = $signed({c_reg.bz[31], c_reg.bz}) - $signed({nx_reg.bz[31], nx_reg.bz});
            d[2] = $signed({c_reg.by[31], c_reg.by}) - $signed({nx_reg.by[31], nx_reg.by});
            d[3] = $signed({c_reg.bx[31], c_reg.bx}) - $signed({ny_reg.bx[31], ny_reg.bx});
            t_next[0] = scale_term(d[0], k_c2dy);
            t_next[1] = scale_term(d[1], k_c2dx);
            t_next[2] = scale_term(d[2], k_c2dx);
            t_next[3] = scale_term(d[3], k_c2dy);
        end
        t_next[4] = scale_term($signed({jx[31], jx}), k_eps);
        t_next[5] = scale_term($signed({jy[31], jy}), k_eps);
        t_next[6] = scale_term($signed({jz[31], jz}), k_eps);
    end

    always_ff @(posedge clk)
    begin
        if (calc)
        begin
            for (int i = 0; i < 7; i++)
            begin
                t_reg[i] <= t_next[i];
            end
        end
    end

    function automatic logic signed [43:0] ext(logic [31:0] v);
        return 44'($signed(v));
    endfunction

    // The updated cell is formed from the registered terms, so it is valid
    // in the cycle after the terms are captured.
    always_comb
    begin
        result = c_reg;
        if (adv_b)
        begin
            result.bx = sat32(ext(c_reg.bx) - 44'(t_reg[0]));
            result.by = sat32(ext(c_reg.by) + 44'(t_reg[1]));
            result.bz = sat32(ext(c_reg.bz) - 44'(t_reg[2]) + 44'(t_reg[3]));
        end
        else
        begin
            result.ex = sat32(ext(c_reg.ex) - 44'(t_reg[4]) + 44'(t_reg[0]));
            result.ey = sat32(ext(c_reg.ey) - 44'(t_reg[5]) - 44'(t_reg[1]));
            result.ez = sat32(ext(c_reg.ez) - 44'(t_reg[6]) + 44'(t_reg[2])
                              - 44'(t_reg[3]));
        end
    end
endmodule

/* sv/fdtd_maxwell_2d_cell_update_unit.sv */
// ----------------------------------------------------------------------------
// FDTD 2D cell update unit
// Yee-grid field store with per-cell E/B advance on a periodic grid.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Beat
// request   in         start / busy      req_type, cell_x, cell_y, value_x/y/z
// result    out        done (strobe)     e_x, e_y, e_z, b_x, b_y, b_z
// config    in         cfg_valid/ready   cfg_index, cfg_data
//
// Every request first reduces its coordinates modulo the grid extents, one
// restoring step per cycle. A write or read then reads the center cell, and
// a write writes it back; busy stays high from acceptance through the write,
// and done strobes as busy falls. An advance reads the center cell, the x
// neighbor and the y neighbor through the single memory read port, forms the
// terms, and writes back, with busy high throughout. A new request can be
// accepted in the done cycle. Reset clears the sequencer and the configuration
// registers; the memories and the request and output registers are not
// cleared. The receiver cannot stall the result.
`include "fdtd_maxwell_2d_cell_update_unit_assert.svh"
module fdtd_maxwell_2d_cell_update_unit
    import fdtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [31:0] value_x,
    input  logic [31:0] value_y,
    input  logic [31:0] value_z,
    output logic        done,
    output logic [31:0] e_x,
    output logic [31:0] e_y,
    output logic [31:0] e_z,
    output logic [31:0] b_x,
    output logic [31:0] b_y,
    output logic [31:0] b_z,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    state_t state_reg, state_next;
    logic [8:0]  gw_reg, gh_reg;
    logic [31:0] k_dx_reg, k_dy_reg, k_c2dx_reg, k_c2dy_reg, k_eps_reg;
    logic [2:0]  req_reg;
    logic [XW-1:0] x_reg, xp_reg;
    logic [YW-1:0] y_reg, yp_reg;
    logic [2:0]  step_reg;
    logic [31:0] vx_reg, vy_reg, vz_reg;
    logic        done_reg;
    cell_t       out_reg;

    logic [8:0]  w_eff, h_eff;
    logic [15:0] x_sub, y_sub;
    logic [XW-1:0] x_next;
    logic [YW-1:0] y_next;
    logic [8:0]  xp_cal, yp_cal;
    logic        is_adv, is_adv_b;
    mem_cmd_t    cmd;
    cell_t       rdata, wdata, result;

    // Effective extents: zero acts as one, above the maximum clamps.
    always_comb
    begin
        w_eff = (gw_reg == 9'd0) ? 9'd1 : ((gw_reg > 9'(MaxNx)) ? 9'(MaxNx) : gw_reg);
        h_eff = (gh_reg == 9'd0) ? 9'd1 : ((gh_reg > 9'(MaxNy)) ? 9'(MaxNy) : gh_reg);
    end

    // One restoring step of the coordinate reduction: the extent shifted by
    // step_reg is taken off when it fits. Eight steps, from a shift of seven
    // down to zero, leave the coordinate modulo the extent.
    always_comb
    begin
        x_sub  = 16'(w_eff) << step_reg;
        y_sub  = 16'(h_eff) << step_reg;
        x_next = x_reg;
        y_next = y_reg;
        if (16'(x_reg) >= x_sub) x_next = x_reg - x_sub[XW-1:0];
        if (16'(y_reg) >= y_sub) y_next = y_reg - y_sub[YW-1:0];
    end

    // The advance direction sets which neighbor: forward for B, backward for E.
    always_comb
    begin
        if (req_reg == REQ_ADVANCE_B)
        begin
            xp_cal = (9'(x_reg) + 9'd1 == w_eff) ? 9'd0 : 9'(x_reg) + 9'd1;
            yp_cal = (9'(y_reg) + 9'd1 == h_eff) ? 9'd0 : 9'(y_reg) + 9'd1;
        end
        else
        begin
            xp_cal = (x_reg == '0) ? w_eff - 9'd1 : 9'(x_reg) - 9'd1;
            yp_cal = (y_reg == '0) ? h_eff - 9'd1 : 9'(y_reg) - 9'd1;
        end
    end

    assign is_adv   = (req_reg == REQ_ADVANCE_B) || (req_reg == REQ_ADVANCE_E);
    assign is_adv_b = (req_reg == REQ_ADVANCE_B);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg     <= 9'd256;
            gh_reg     <= 9'd256;
            k_dx_reg   <= '0;
            k_dy_reg   <= '0;
            k_c2dx_reg <= '0;
            k_c2dy_reg <= '0;
            k_eps_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_W: gw_reg     <= cfg_data[8:0];
                CFG_GRID_H: gh_reg     <= cfg_data[8:0];
                CFG_DT_DX:  k_dx_reg   <= cfg_data;
                CFG_DT_DY:  k_dy_reg   <= cfg_data;
                CFG_C2_DX:  k_c2dx_reg <= cfg_data;
                CFG_C2_DY:  k_c2dy_reg <= cfg_data;
                CFG_DT_EPS: k_eps_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg  <= req_type;
            x_reg    <= cell_x;
            y_reg    <= cell_y;
            step_reg <= 3'd7;
            vx_reg   <= value_x;
            vy_reg   <= value_y;
            vz_reg   <= value_z;
        end
        else if (state_reg == ST_REDUCE)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            step_reg <= step_reg - 3'd1;
        end
        if (state_reg == ST_RD_CENTER)
        begin
            xp_reg <= xp_cal[XW-1:0];
            yp_reg <= yp_cal[YW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WRITE);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = ST_REDUCE;
            ST_REDUCE:    if (step_reg == 3'd0) state_next = ST_RD_CENTER;
            ST_RD_CENTER: state_next = is_adv ? ST_RD_NX : ST_WRITE;
            ST_RD_NX:     state_next = ST_RD_NY;
            ST_RD_NY:     state_next = ST_CALC;
            ST_CALC:      state_next = ST_SUM;
            ST_SUM:       state_next = ST_WRITE;
            ST_WRITE:     state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory commands. Read data for an address issued in one state is registered
    // in the memory and is captured in the following state.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_RD_CENTER:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = {x_reg, y_reg};
            end
            ST_RD_NX:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = {xp_reg, y_reg};
            end
            ST_RD_NY:
            begin
                cmd.rd   = 1'b1;
                cmd.addr = {x_reg, yp_reg};
            end
            ST_WRITE:
            begin
                cmd.addr = {x_reg, y_reg};
                cmd.we_e = (req_reg == REQ_WRITE_E) || (req_reg == REQ_ADVANCE_E);
                cmd.we_b = (req_reg == REQ_WRITE_B) || (req_reg == REQ_ADVANCE_B);
            end
            default: ;
        endcase
    end

    fdtd_field_mem u_mem (
        .clk   (clk),
        .cmd   (cmd),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Terms are registered at the end of the sum state, so the updated cell
    // is ready in the write state.
    fdtd_datapath u_dp (
        .clk        (clk),
        .cap_center (state_reg == ST_RD_NX || (state_reg == ST_WRITE && !is_adv)),
        .cap_nx     (state_reg == ST_RD_NY),
        .cap_ny     (state_reg == ST_CALC),
        .calc       (state_reg == ST_SUM),
        .adv_b      (is_adv_b),
        .rdata      (rdata),
        .jx         (vx_reg),
        .jy         (vy_reg),
        .jz         (vz_reg),
        .k_dx       (k_dx_reg),
        .k_dy       (k_dy_reg),
        .k_c2dx     (k_c2dx_reg),
        .k_c2dy     (k_c2dy_reg),
        .k_eps      (k_eps_reg),
        .result     (result)
    );

    // Write data and the cell returned to the user. For a plain write or
    // read the center word comes straight from the memory read port.
    always_comb
    begin
        if (is_adv)
        begin
            wdata = result;
        end
        else
        begin
            wdata = rdata;
            if (req_reg == REQ_WRITE_E)
            begin
                wdata.ex = vx_reg;
                wdata.ey = vy_reg;
                wdata.ez = vz_reg;
            end
            else if (req_reg == REQ_WRITE_B)
            begin
                wdata.bx = vx_reg;
                wdata.by = vy_reg;
                wdata.bz = vz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            out_reg <= wdata;
        end
    end

    assign done = done_reg;
    assign e_x  = out_reg.ex;
    assign e_y  = out_reg.ey;
    assign e_z  = out_reg.ez;
    assign b_x  = out_reg.bx;
    assign b_y  = out_reg.by;
    assign b_z  = out_reg.bz;

    `FDTD_ASSERT_NEXT(a_done_after_write, state_reg == ST_WRITE, done)
    `FDTD_ASSERT_IMPL(a_no_done_when_busy, done, state_reg == ST_IDLE)
    `FDTD_ASSERT_IMPL(a_write_only_in_write, cmd.we_e || cmd.we_b, state_reg == ST_WRITE)
endmodule
